@@ hdl/thin_pkg.sv @@
// shared constants and types for the binary image thinning block
package thin_pkg;

    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 256;

    localparam int CFG_DIM_W  = 9;
    localparam int CFG_LIM_W  = 8;
    localparam int PASS_W     = 9;
    localparam int REMOVED_W  = 17;
    localparam int PADDR_W    = 4;
    localparam int PDATA_W    = 32;

    localparam logic [REMOVED_W-1:0] REMOVED_MAX = '1;

    localparam logic [CFG_DIM_W-1:0] WIDTH_RST  = 9'd256;
    localparam logic [CFG_DIM_W-1:0] HEIGHT_RST = 9'd256;
    localparam logic [CFG_LIM_W-1:0] LIMIT_RST  = 8'd15;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_RUN   = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_LIMIT  = 2'd2,
        REG_NONE   = 2'd3
    } t_reg;

endpackage

@@ hdl/thin_ram.sv @@
// generic single-port synchronous ram with registered read
module thin_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

@@ hdl/binary_image_thinning_top.sv @@
// top level of the binary image thinning block: command handling and run sequencer
//
// The block holds a binary frame in an internal memory and takes one command
// request whenever start is high and busy is low: write a pixel, read a pixel,
// or run two-subiteration parallel thinning over the frame in use. Every request gives exactly
// one result, shown for a single cycle with o_result_valid high; the receiver
// cannot stall it, so it must take results as they come. A write (and the
// unused command) gives its result in the cycle after the request and busy
// stays low, so writes stream one per cycle. A read holds busy in S_RDWAIT
// while the frame memory returns the pixel, and its result is registered as
// that state ends. A run holds busy for the whole run: for each pixel of the
// interior it makes nine reads of the single frame memory port (center and
// eight neighbors) in S_FETCH, then evaluates the pixel and writes its mark in
// S_EVAL; a second sweep through S_APRD and S_APWR then applies the removal
// marks. Each pass holds two such subiterations. Border pixels never change.
// Pixels must be written before they are read or thinned. Configuration must be
// written over the APB-style port only while the block is idle; the block
// itself does not enforce it.
module binary_image_thinning_top #(
    parameter int MAX_WIDTH  = thin_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = thin_pkg::MAX_HEIGHT_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // command request
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        i_cmd,
    input  logic [7:0]                        i_row,
    input  logic [7:0]                        i_col,
    input  logic                              i_pixel_in,
    // result
    output logic                              o_result_valid,
    output logic                              o_pixel_out,
    output logic [thin_pkg::PASS_W-1:0]       o_passes_done,
    output logic [thin_pkg::REMOVED_W-1:0]    o_pixels_removed,
    output logic                              o_converged,
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [thin_pkg::PADDR_W-1:0]      paddr,
    input  logic [thin_pkg::PDATA_W-1:0]      pwdata,
    output logic [thin_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int CW    = $clog2(MAX_WIDTH);
    // widths wide enough to hold the dimension in use plus a little headroom
    localparam int HEW   = ((thin_pkg::CFG_DIM_W > $clog2(MAX_HEIGHT + 1)) ?
                            thin_pkg::CFG_DIM_W : $clog2(MAX_HEIGHT + 1)) + 1;
    localparam int WEW   = ((thin_pkg::CFG_DIM_W > $clog2(MAX_WIDTH + 1)) ?
                            thin_pkg::CFG_DIM_W : $clog2(MAX_WIDTH + 1)) + 1;
    // the per-pass removal counter is sized for twice the store depth
    localparam int CNTW  = $clog2(2 * DEPTH + 1);
    localparam int SUMW  = ((CNTW > thin_pkg::REMOVED_W) ? CNTW : thin_pkg::REMOVED_W) + 1;
    localparam logic [AW-1:0] ROWSTEP = AW'(MAX_WIDTH);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RDWAIT,
        S_SCAN,
        S_FETCH,
        S_EVAL,
        S_APRD,
        S_APWR,
        S_SUBEND
    } t_state;

    // configuration registers
    logic [thin_pkg::CFG_DIM_W-1:0] r_width;
    logic [thin_pkg::CFG_DIM_W-1:0] r_height;
    logic [thin_pkg::CFG_LIM_W-1:0] r_limit;

    // control and working state
    t_state                         r_state;
    logic [RW-1:0]                  r_row;
    logic [CW-1:0]                  r_col;
    logic [3:0]                     r_k;
    logic [8:0]                     r_nb;
    logic                           r_sub;
    logic [CNTW-1:0]                r_sub_cnt;
    logic [thin_pkg::REMOVED_W-1:0] r_total;
    logic [thin_pkg::PASS_W-1:0]    r_passes;
    logic [HEW-1:0]                 r_h;
    logic [WEW-1:0]                 r_w;
    logic                           r_inside;

    // reported state and result strobe
    logic [thin_pkg::PASS_W-1:0]    r_pass_count;
    logic [thin_pkg::REMOVED_W-1:0] r_removed;
    logic                           r_conv;
    logic                           r_valid;
    logic                           r_pix;

    // memory ports
    logic          frame_we, frame_wdata, frame_rdata;
    logic [AW-1:0] frame_addr;
    logic          mark_we, mark_wdata, mark_rdata;
    logic [AW-1:0] mark_addr;

    logic                           accept;
    logic                           cfg_wr;
    logic                           in_range;
    logic [AW-1:0]                  cmd_addr;
    logic [AW-1:0]                  base;
    logic                           mark;
    logic [3:0]                     nb_cnt;
    logic [3:0]                     nb_trans;
    logic                           col_more;
    logic                           row_more;
    logic [thin_pkg::PASS_W-1:0]    passes_n;
    logic [SUMW-1:0]                sum_wide;
    logic [thin_pkg::REMOVED_W-1:0] sum_sat;
    logic                           run_done;
    logic [HEW-1:0]                 h_eff;
    logic [WEW-1:0]                 w_eff;

    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    assign in_range = ({5'd0, i_row} < 13'(MAX_HEIGHT)) && ({5'd0, i_col} < 13'(MAX_WIDTH));
    assign cmd_addr = AW'(i_row) * ROWSTEP + AW'(i_col);
    assign base     = AW'(r_row) * ROWSTEP + AW'(r_col);

    // frame size in use, saturated to the store
    assign h_eff = (HEW'(r_height) > HEW'(MAX_HEIGHT)) ? HEW'(MAX_HEIGHT) : HEW'(r_height);
    assign w_eff = (WEW'(r_width) > WEW'(MAX_WIDTH)) ? WEW'(MAX_WIDTH) : WEW'(r_width);

    // interior scan order: columns 1..w-2 within rows 1..h-2
    assign col_more = (WEW'(r_col) + WEW'(2)) < r_w;
    assign row_more = (HEW'(r_row) + HEW'(2)) < r_h;

    // neighbor test on the fetched ring; r_nb[0] is the center,
    // r_nb[1..8] run N, NE, E, SE, S, SW, W, NW
    always_comb begin
        logic [7:0] n;
        logic       t1, t2;
        n        = r_nb[8:1];
        nb_cnt   = 4'($countones(n));
        nb_trans = '0;
        for (int k = 0; k < 8; k++) begin
            nb_trans = nb_trans + 4'(!n[k] && n[(k + 1) % 8]);
        end
        if (!r_sub) begin
            t1 = !(n[0] && n[2] && n[4]);
            t2 = !(n[2] && n[4] && n[6]);
        end else begin
            t1 = !(n[0] && n[2] && n[6]);
            t2 = !(n[0] && n[4] && n[6]);
        end
        mark = r_nb[0] && (nb_cnt inside {[4'd2:4'd6]}) && (nb_trans == 4'd1) && t1 && t2;
    end

    // pass bookkeeping at the end of the second subiteration
    assign passes_n = r_passes + thin_pkg::PASS_W'(1);
    assign sum_wide = SUMW'(r_total) + SUMW'(r_sub_cnt);
    assign sum_sat  = (sum_wide > SUMW'(thin_pkg::REMOVED_MAX)) ?
                      thin_pkg::REMOVED_MAX : sum_wide[thin_pkg::REMOVED_W-1:0];
    assign run_done = (r_sub_cnt == '0) || (passes_n > thin_pkg::PASS_W'(r_limit));

    // memory port steering
    always_comb begin
        frame_we    = 1'b0;
        frame_wdata = 1'b0;
        frame_addr  = base;
        mark_we     = 1'b0;
        mark_wdata  = mark;
        mark_addr   = base;
        case (r_state)
            S_IDLE: begin
                frame_addr  = cmd_addr;
                frame_wdata = i_pixel_in;
                frame_we    = accept && (thin_pkg::t_cmd'(i_cmd) == thin_pkg::CMD_WRITE)
                              && in_range;
            end
            S_FETCH: begin
                case (r_k)
                    4'd1:    frame_addr = base - ROWSTEP;
                    4'd2:    frame_addr = base - ROWSTEP + AW'(1);
                    4'd3:    frame_addr = base + AW'(1);
                    4'd4:    frame_addr = base + ROWSTEP + AW'(1);
                    4'd5:    frame_addr = base + ROWSTEP;
                    4'd6:    frame_addr = base + ROWSTEP - AW'(1);
                    4'd7:    frame_addr = base - AW'(1);
                    4'd8:    frame_addr = base - ROWSTEP - AW'(1);
                    default: frame_addr = base;
                endcase
            end
            S_EVAL: begin
                mark_we = 1'b1;
            end
            S_APWR: begin
                frame_we = mark_rdata;
            end
            default: begin
            end
        endcase
    end

    thin_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_frame (
        .i_clk   (i_clk),
        .i_we    (frame_we),
        .i_addr  (frame_addr),
        .i_wdata (frame_wdata),
        .o_rdata (frame_rdata)
    );

    thin_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_marks (
        .i_clk   (i_clk),
        .i_we    (mark_we),
        .i_addr  (mark_addr),
        .i_wdata (mark_wdata),
        .o_rdata (mark_rdata)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= thin_pkg::WIDTH_RST;
            r_height <= thin_pkg::HEIGHT_RST;
            r_limit  <= thin_pkg::LIMIT_RST;
        end else if (cfg_wr) begin
            case (thin_pkg::t_reg'(paddr[3:2]))
                thin_pkg::REG_WIDTH:  r_width  <= pwdata[thin_pkg::CFG_DIM_W-1:0];
                thin_pkg::REG_HEIGHT: r_height <= pwdata[thin_pkg::CFG_DIM_W-1:0];
                thin_pkg::REG_LIMIT:  r_limit  <= pwdata[thin_pkg::CFG_LIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (thin_pkg::t_reg'(paddr[3:2]))
            thin_pkg::REG_WIDTH:  prdata = thin_pkg::PDATA_W'(r_width);
            thin_pkg::REG_HEIGHT: prdata = thin_pkg::PDATA_W'(r_height);
            thin_pkg::REG_LIMIT:  prdata = thin_pkg::PDATA_W'(r_limit);
            default:              prdata = '0;
        endcase
    end

    // command sequencer and run engine
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_valid      <= 1'b0;
            r_pix        <= 1'b0;
            r_pass_count <= '0;
            r_removed    <= '0;
            r_conv       <= 1'b0;
            r_k          <= '0;
            r_sub        <= 1'b0;
            r_sub_cnt    <= '0;
            r_total      <= '0;
            r_passes     <= '0;
            r_row        <= '0;
            r_col        <= '0;
            r_inside     <= 1'b0;
            r_h          <= '0;
            r_w          <= '0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        case (thin_pkg::t_cmd'(i_cmd))
                            thin_pkg::CMD_READ: begin
                                r_inside <= in_range;
                                r_state  <= S_RDWAIT;
                            end
                            thin_pkg::CMD_RUN: begin
                                r_h       <= h_eff;
                                r_w       <= w_eff;
                                r_passes  <= '0;
                                r_total   <= '0;
                                r_sub     <= 1'b0;
                                r_sub_cnt <= '0;
                                r_row     <= RW'(1);
                                r_col     <= CW'(1);
                                r_state   <= S_SCAN;
                            end
                            default: begin
                                // write and the unused command answer at once
                                r_pix   <= 1'b0;
                                r_valid <= 1'b1;
                            end
                        endcase
                    end
                end
                S_RDWAIT: begin
                    r_pix   <= r_inside && frame_rdata;
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_SCAN: begin
                    r_k <= '0;
                    // frames under three in either direction have no interior
                    if ((r_h >= HEW'(3)) && (r_w >= WEW'(3))) begin
                        r_state <= S_FETCH;
                    end else begin
                        r_state <= S_SUBEND;
                    end
                end
                S_FETCH: begin
                    if (r_k != 4'd0) begin
                        r_nb[r_k - 4'd1] <= frame_rdata;
                    end
                    if (r_k == 4'd9) begin
                        r_state <= S_EVAL;
                    end else begin
                        r_k <= r_k + 4'd1;
                    end
                end
                S_EVAL: begin
                    r_k <= '0;
                    if (col_more) begin
                        r_col   <= r_col + CW'(1);
                        r_state <= S_FETCH;
                    end else if (row_more) begin
                        r_col   <= CW'(1);
                        r_row   <= r_row + RW'(1);
                        r_state <= S_FETCH;
                    end else begin
                        r_col   <= CW'(1);
                        r_row   <= RW'(1);
                        r_state <= S_APRD;
                    end
                end
                S_APRD: begin
                    r_state <= S_APWR;
                end
                S_APWR: begin
                    if (mark_rdata) begin
                        r_sub_cnt <= r_sub_cnt + CNTW'(1);
                    end
                    if (col_more) begin
                        r_col   <= r_col + CW'(1);
                        r_state <= S_APRD;
                    end else if (row_more) begin
                        r_col   <= CW'(1);
                        r_row   <= r_row + RW'(1);
                        r_state <= S_APRD;
                    end else begin
                        r_state <= S_SUBEND;
                    end
                end
                S_SUBEND: begin
                    r_row <= RW'(1);
                    r_col <= CW'(1);
                    if (!r_sub) begin
                        r_sub   <= 1'b1;
                        r_state <= S_SCAN;
                    end else if (run_done) begin
                        r_pass_count <= passes_n;
                        r_removed    <= sum_sat;
                        r_conv       <= (r_sub_cnt == '0);
                        r_pix        <= 1'b0;
                        r_valid      <= 1'b1;
                        r_state      <= S_IDLE;
                    end else begin
                        r_passes  <= passes_n;
                        r_total   <= sum_sat;
                        r_sub     <= 1'b0;
                        r_sub_cnt <= '0;
                        r_state   <= S_SCAN;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_result_valid   = r_valid;
    assign o_pixel_out      = r_pix;
    assign o_passes_done    = r_pass_count;
    assign o_pixels_removed = r_removed;
    assign o_converged      = r_conv;

    // a write request answers in the very next cycle
    a_write_answers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_cmd == thin_pkg::CMD_WRITE) |=> o_result_valid && !busy)
        else $error("write request did not answer in the next cycle");

    // a read request first holds busy with no result, then answers
    a_read_answers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_cmd == thin_pkg::CMD_READ) |=> busy && !o_result_valid ##1 o_result_valid)
        else $error("read request timing broken");

    // a converged run has run at least one pass
    a_conv_passes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_conv |-> (r_pass_count != '0))
        else $error("converged flag without any pass");

    // no result while a run is still sweeping
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_APWR) |=> !o_result_valid)
        else $error("result during removal sweep");

endmodule

@@ sim/testbench.sv @@
// testbench for the binary image thinning block: directed and random command traffic
`timescale 1ns / 1ps

module testbench;

    localparam int STALL_LIMIT = 8000000;
    localparam int ITEMS       = 1950;

    typedef struct packed {
        logic                           pix;
        logic [thin_pkg::PASS_W-1:0]    passes;
        logic [thin_pkg::REMOVED_W-1:0] removed;
        logic                           conv;
    } t_thin_res;

    typedef struct {
        thin_pkg::t_cmd cmd;
        logic [7:0]     row;
        logic [7:0]     col;
        logic           pix;
        bit             typed;
        t_thin_res      res;
    } t_stim_row;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           start;
    logic                           busy;
    logic [1:0]                     i_cmd;
    logic [7:0]                     i_row;
    logic [7:0]                     i_col;
    logic                           i_pixel_in;
    logic                           o_result_valid;
    logic                           o_pixel_out;
    logic [thin_pkg::PASS_W-1:0]    o_passes_done;
    logic [thin_pkg::REMOVED_W-1:0] o_pixels_removed;
    logic                           o_converged;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [thin_pkg::PADDR_W-1:0]   paddr;
    logic [thin_pkg::PDATA_W-1:0]   pwdata;
    logic [thin_pkg::PDATA_W-1:0]   prdata;
    logic                           pready;

    binary_image_thinning_top u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_cmd            (i_cmd),
        .i_row            (i_row),
        .i_col            (i_col),
        .i_pixel_in       (i_pixel_in),
        .o_result_valid   (o_result_valid),
        .o_pixel_out      (o_pixel_out),
        .o_passes_done    (o_passes_done),
        .o_pixels_removed (o_pixels_removed),
        .o_converged      (o_converged),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    // mirror of the block: frame, written map, registers, run counters
    bit              img [256][256];
    bit              seen [256][256];
    bit              marks [256][256];
    int unsigned     cfg_w, cfg_h, cfg_lim;
    t_thin_res       last_run;

    t_thin_res       expected_q [$];
    int              errors = 0;
    int              stall_cnt = 0;
    int              sent;
    bit              cur_typed;
    t_thin_res       cur_res;
    bit              idle_on;
    int              lims [4] = '{0, 1, 255, 3};

    // one subiteration over the interior, marks first and clears together
    function automatic int thin_subpass(int h, int w, bit second);
        int  removed;
        int  cnt;
        int  trans;
        bit  n [8];
        bit  t1, t2;
        removed = 0;
        for (int r = 1; r + 1 < h; r++) begin
            for (int c = 1; c + 1 < w; c++) begin
                marks[r][c] = 0;
                if (img[r][c]) begin
                    n[0] = img[r-1][c];
                    n[1] = img[r-1][c+1];
                    n[2] = img[r][c+1];
                    n[3] = img[r+1][c+1];
                    n[4] = img[r+1][c];
                    n[5] = img[r+1][c-1];
                    n[6] = img[r][c-1];
                    n[7] = img[r-1][c-1];
                    cnt = 0;
                    trans = 0;
                    for (int k = 0; k < 8; k++) begin
                        cnt += int'(n[k]);
                        if (!n[k] && n[(k+1)%8]) trans++;
                    end
                    if (!second) begin
                        t1 = !(n[0] && n[2] && n[4]);
                        t2 = !(n[2] && n[4] && n[6]);
                    end else begin
                        t1 = !(n[0] && n[2] && n[6]);
                        t2 = !(n[0] && n[4] && n[6]);
                    end
                    if (cnt >= 2 && cnt <= 6 && trans == 1 && t1 && t2) marks[r][c] = 1;
                end
            end
        end
        for (int r = 1; r + 1 < h; r++)
            for (int c = 1; c + 1 < w; c++)
                if (marks[r][c]) begin
                    img[r][c] = 0;
                    removed++;
                end
        return removed;
    endfunction

    function automatic void thin_run();
        int h, w, passes, total, cnt;
        h = (cfg_h > 256) ? 256 : int'(cfg_h);
        w = (cfg_w > 256) ? 256 : int'(cfg_w);
        passes = 0;
        total = 0;
        forever begin
            cnt = thin_subpass(h, w, 0);
            cnt += thin_subpass(h, w, 1);
            passes++;
            total += cnt;
            if (total > int'(thin_pkg::REMOVED_MAX)) total = int'(thin_pkg::REMOVED_MAX);
            if (cnt == 0 || passes > int'(cfg_lim)) break;
        end
        last_run.passes  = passes[thin_pkg::PASS_W-1:0];
        last_run.removed = total[thin_pkg::REMOVED_W-1:0];
        last_run.conv    = (cnt == 0);
    endfunction

    function automatic t_thin_res thin_predict(thin_pkg::t_cmd c, logic [7:0] r,
                                               logic [7:0] col, logic p);
        t_thin_res res;
        res = last_run;
        res.pix = 0;
        case (c)
            thin_pkg::CMD_WRITE: begin
                img[r][col] = p;
                seen[r][col] = 1;
            end
            thin_pkg::CMD_RUN: begin
                thin_run();
                res = last_run;
                res.pix = 0;
            end
            thin_pkg::CMD_READ: res.pix = img[r][col];
            default: ;
        endcase
        return res;
    endfunction

    // clock
    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // result check first, then record the request taken at this edge
    always @(posedge i_clk) begin
        t_thin_res want;
        t_thin_res got;
        if (i_rst_n && o_result_valid) begin
            got = '{o_pixel_out, o_passes_done, o_pixels_removed, o_converged};
            if (expected_q.size() == 0) begin
                $display("%0t: result with none pending, expected none, actual %h",
                         $realtime, got);
                errors++;
            end else begin
                want = expected_q.pop_front();
                if (got.pix !== want.pix) begin
                    $display("%0t: pixel_out expected %0d actual %0d",
                             $realtime, want.pix, got.pix);
                    errors++;
                end
                if (got.passes !== want.passes) begin
                    $display("%0t: passes_done expected %0d actual %0d",
                             $realtime, want.passes, got.passes);
                    errors++;
                end
                if (got.removed !== want.removed) begin
                    $display("%0t: pixels_removed expected %0d actual %0d",
                             $realtime, want.removed, got.removed);
                    errors++;
                end
                if (got.conv !== want.conv) begin
                    $display("%0t: converged expected %0d actual %0d",
                             $realtime, want.conv, got.conv);
                    errors++;
                end
            end
        end
        if (i_rst_n && start && !busy) begin
            want = thin_predict(thin_pkg::t_cmd'(i_cmd), i_row, i_col, i_pixel_in);
            expected_q.push_back(cur_typed ? cur_res : want);
        end
    end

    // watchdog on cycles with no request taken and no result
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_result_valid) begin
            stall_cnt <= 0;
        end else if (stall_cnt >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
    end

    // one command request, with an optional idle burst first
    task automatic send(thin_pkg::t_cmd c, logic [7:0] r, logic [7:0] col, logic p,
                        bit typed = 0, t_thin_res tv = '0);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            start = 0;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
        start      = 1;
        i_cmd      = c;
        i_row      = r;
        i_col      = col;
        i_pixel_in = p;
        cur_typed  = typed;
        cur_res    = tv;
        // busy only moves at the rising edge, so it is stable at the falling one
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
        @(negedge i_clk);
        sent++;
    endtask

    task automatic drain();
        start = 0;
        while (expected_q.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic cfg_write(thin_pkg::t_reg idx, int unsigned value);
        psel    = 1;
        pwrite  = 1;
        penable = 0;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 0;
        penable = 0;
        pwrite  = 0;
        case (idx)
            thin_pkg::REG_WIDTH:  cfg_w   = value & 32'h1FF;
            thin_pkg::REG_HEIGHT: cfg_h   = value & 32'h1FF;
            thin_pkg::REG_LIMIT:  cfg_lim = value & 32'hFF;
            default: ;
        endcase
    endtask

    task automatic set_frame(int unsigned w, int unsigned h, int unsigned lim);
        drain();
        cfg_write(thin_pkg::REG_WIDTH, w);
        cfg_write(thin_pkg::REG_HEIGHT, h);
        cfg_write(thin_pkg::REG_LIMIT, lim);
    endtask

    // every pixel of the frame in use gets a value, mostly foreground, set at random
    task automatic fill_frame();
        int h, w;
        h = (cfg_h > 256) ? 256 : int'(cfg_h);
        w = (cfg_w > 256) ? 256 : int'(cfg_w);
        for (int r = 0; r < h; r++)
            for (int c = 0; c < w; c++)
                send(thin_pkg::CMD_WRITE, 8'(r), 8'(c), $urandom_range(0, 9) < 7);
    endtask

    // random traffic inside one frame setting
    task automatic random_phase(int count);
        int h, w, pick;
        logic [7:0] r, c;
        h = (cfg_h > 256) ? 256 : int'(cfg_h);
        w = (cfg_w > 256) ? 256 : int'(cfg_w);
        idle_on = $urandom_range(0, 2) != 0;
        for (int i = 0; i < count; i++) begin
            if (sent > ITEMS * 85 / 100) idle_on = 0;
            pick = int'($urandom_range(0, 99));
            if (h > 0 && w > 0) begin
                r = 8'($urandom_range(0, h - 1));
                c = 8'($urandom_range(0, w - 1));
            end else begin
                r = 0;
                c = 0;
            end
            if (pick < 45) begin
                // mostly inside the frame, sometimes anywhere in the store
                if ($urandom_range(0, 4) == 0) begin
                    r = 8'($urandom);
                    c = 8'($urandom);
                end
                send(thin_pkg::CMD_WRITE, r, c, 1'($urandom));
            end else if (pick < 87) begin
                if ($urandom_range(0, 2) == 0) begin
                    r = 8'($urandom);
                    c = 8'($urandom);
                end
                if (seen[r][c]) send(thin_pkg::CMD_READ, r, c, 1'($urandom));
            end else if (pick < 94) begin
                send(thin_pkg::CMD_RUN, 8'($urandom), 8'($urandom), 1'($urandom));
            end else begin
                send(thin_pkg::CMD_NONE, 8'($urandom), 8'($urandom), 1'($urandom));
            end
        end
    endtask

    // directed rows, all but the first on a 3x3 frame: extremes, store edges, unused command,
    // one removal then a converged rerun
    t_stim_row directed [21] = '{
        '{thin_pkg::CMD_NONE,  8'd0,   8'd0,   1'b1, 1, '{1'b0, 9'd0, 17'd0, 1'b0}},
        '{thin_pkg::CMD_WRITE, 8'd255, 8'd255, 1'b1, 1, '{1'b0, 9'd0, 17'd0, 1'b0}},
        '{thin_pkg::CMD_READ,  8'd255, 8'd255, 1'b0, 1, '{1'b1, 9'd0, 17'd0, 1'b0}},
        '{thin_pkg::CMD_WRITE, 8'd0,   8'd255, 1'b0, 0, '0},
        '{thin_pkg::CMD_READ,  8'd0,   8'd255, 1'b1, 1, '{1'b0, 9'd0, 17'd0, 1'b0}},
        '{thin_pkg::CMD_WRITE, 8'd255, 8'd0,   1'b1, 0, '0},
        '{thin_pkg::CMD_READ,  8'd255, 8'd0,   1'b0, 0, '0},
        '{thin_pkg::CMD_WRITE, 8'd0,   8'd0,   1'b0, 0, '0},
        '{thin_pkg::CMD_WRITE, 8'd0,   8'd1,   1'b1, 0, '0},
        '{thin_pkg::CMD_WRITE, 8'd0,   8'd2,   1'b1, 0, '0},
        '{thin_pkg::CMD_WRITE, 8'd1,   8'd0,   1'b0, 0, '0},
        '{thin_pkg::CMD_WRITE, 8'd1,   8'd1,   1'b1, 0, '0},
        '{thin_pkg::CMD_WRITE, 8'd1,   8'd2,   1'b0, 0, '0},
        '{thin_pkg::CMD_WRITE, 8'd2,   8'd0,   1'b0, 0, '0},
        '{thin_pkg::CMD_WRITE, 8'd2,   8'd1,   1'b0, 0, '0},
        '{thin_pkg::CMD_WRITE, 8'd2,   8'd2,   1'b0, 0, '0},
        '{thin_pkg::CMD_RUN,   8'd0,   8'd0,   1'b0, 1, '{1'b0, 9'd1, 17'd1, 1'b0}},
        '{thin_pkg::CMD_READ,  8'd1,   8'd1,   1'b1, 1, '{1'b0, 9'd1, 17'd1, 1'b0}},
        '{thin_pkg::CMD_RUN,   8'd0,   8'd0,   1'b0, 1, '{1'b0, 9'd1, 17'd0, 1'b1}},
        '{thin_pkg::CMD_READ,  8'd0,   8'd1,   1'b0, 1, '{1'b1, 9'd1, 17'd0, 1'b1}},
        '{thin_pkg::CMD_NONE,  8'd255, 8'd255, 1'b1, 1, '{1'b0, 9'd1, 17'd0, 1'b1}}
    };

    initial begin
        sent       = 0;
        idle_on    = 0;
        cur_typed  = 0;
        cur_res    = '0;
        start      = 0;
        i_cmd      = thin_pkg::CMD_NONE;
        i_row      = 0;
        i_col      = 0;
        i_pixel_in = 0;
        psel       = 0;
        penable    = 0;
        pwrite     = 0;
        paddr      = 0;
        pwdata     = 0;
        cfg_w      = 32'(thin_pkg::WIDTH_RST);
        cfg_h      = 32'(thin_pkg::HEIGHT_RST);
        cfg_lim    = 32'(thin_pkg::LIMIT_RST);
        last_run   = '0;
        i_rst_n    = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // first request runs on reset registers, then narrow to 3x3, one pass
        send(directed[0].cmd, directed[0].row, directed[0].col, directed[0].pix,
             directed[0].typed, directed[0].res);
        set_frame(3, 3, 0);
        for (int i = 1; i < $size(directed); i++)
            send(directed[i].cmd, directed[i].row, directed[i].col, directed[i].pix,
                 directed[i].typed, directed[i].res);

        // width beyond the store saturates, deepest pass limit
        set_frame(511, 3, 255);
        fill_frame();
        random_phase(60);
        // tallest frame, narrow
        set_frame(3, 256, 1);
        fill_frame();
        random_phase(60);
        // frames with no interior
        set_frame(2, 5, 7);
        fill_frame();
        random_phase(30);
        set_frame(6, 0, 3);
        random_phase(30);

        while (sent < ITEMS) begin
            set_frame($urandom_range(3, 9), $urandom_range(3, 9),
                      $urandom_range(0, 1) ? 32'(lims[$urandom_range(0, 3)])
                                           : $urandom_range(0, 255));
            fill_frame();
            random_phase(int'($urandom_range(60, 150)));
        end

        drain();
        repeat (20) @(negedge i_clk);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
hdl/thin_pkg.sv
hdl/thin_ram.sv
hdl/binary_image_thinning_top.sv
sim/testbench.sv
